### rtl/sdsh_pkg.sv
`default_nettype none
package sdsh_pkg;

	typedef enum logic [5:0] {
		PH_IDLE         = 6'd0,
		PH_IDLE_CLK     = 6'd1,
		PH_C0_FRAME     = 6'd2,
		PH_C0_POLL      = 6'd3,
		PH_C0_POST      = 6'd4,
		PH_C8_FRAME     = 6'd5,
		PH_C8_POLL      = 6'd6,
		PH_C8_R7        = 6'd7,
		PH_C8_POST      = 6'd8,
		PH_C55_FRAME    = 6'd9,
		PH_C55_POLL     = 6'd10,
		PH_C55_POST     = 6'd11,
		PH_C41_FRAME    = 6'd12,
		PH_C41_POLL     = 6'd13,
		PH_C41_POST     = 6'd14,
		PH_GAP_WAIT     = 6'd15,
		PH_C58_FRAME    = 6'd16,
		PH_C58_POLL     = 6'd17,
		PH_C58_OCR      = 6'd18,
		PH_C58_POST     = 6'd19,
		PH_C16_FRAME    = 6'd20,
		PH_C16_POLL     = 6'd21,
		PH_C16_POST     = 6'd22,
		PH_RD_FRAME     = 6'd23,
		PH_RD_POLL      = 6'd24,
		PH_RD_TOKEN     = 6'd25,
		PH_RD_DATA      = 6'd26,
		PH_RD_CRC       = 6'd27,
		PH_WR_FRAME     = 6'd29,
		PH_WR_POLL      = 6'd30,
		PH_WR_TOKEN     = 6'd31,
		PH_WR_DATA      = 6'd32,
		PH_WR_CRC       = 6'd33,
		PH_WR_RESP      = 6'd34,
		PH_WR_BUSY      = 6'd35,
		PH_POST_OK      = 6'd37,
		PH_POST_CMD     = 6'd38,
		PH_POST_NOTOKEN = 6'd39,
		PH_POST_DATAREJ = 6'd40
	} phase_t;

	typedef enum logic [2:0] {
		MD_INIT  = 3'd0,
		MD_READ  = 3'd1,
		MD_WRITE = 3'd2,
		MD_XCHG  = 3'd3,
		MD_TICK  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_RESET_BAD    = 3'd1,
		ST_INIT_TIMEOUT = 3'd2,
		ST_BLOCKLEN     = 3'd3,
		ST_CMD_REJ      = 3'd4,
		ST_DATA_REJ     = 3'd5,
		ST_NO_TOKEN     = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		RG_IDLE_CLK  = 3'd0,
		RG_RESP_TO   = 3'd1,
		RG_RETRY_LIM = 3'd2,
		RG_RETRY_GAP = 3'd3,
		RG_TOKEN_WT  = 3'd4,
		RG_BUSY_WT   = 3'd5
	} reg_idx_t;

	localparam logic [23:0] MAX24 = 24'hFFFFFF;
	localparam logic [31:0] CMD8_ARG = 32'h0000_01AA;
	localparam logic [31:0] ACMD41_ARG = 32'h4000_0000;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] FILL_BYTE = 8'hFF;
	localparam logic [7:0] CMD_MARK = 8'h40;

	function automatic logic is_frame(input phase_t ph);
		return ph == PH_C0_FRAME || ph == PH_C8_FRAME || ph == PH_C55_FRAME ||
			ph == PH_C41_FRAME || ph == PH_C58_FRAME || ph == PH_C16_FRAME ||
			ph == PH_RD_FRAME || ph == PH_WR_FRAME;
	endfunction

	function automatic logic is_poll(input phase_t ph);
		return ph == PH_C0_POLL || ph == PH_C8_POLL || ph == PH_C55_POLL ||
			ph == PH_C41_POLL || ph == PH_C58_POLL || ph == PH_C16_POLL ||
			ph == PH_RD_POLL || ph == PH_WR_POLL;
	endfunction

	function automatic logic cs_high(input phase_t ph);
		return ph == PH_IDLE || ph == PH_GAP_WAIT || ph == PH_IDLE_CLK ||
			ph == PH_C0_POST || ph == PH_C8_POST || ph == PH_C55_POST ||
			ph == PH_C41_POST || ph == PH_C58_POST || ph == PH_C16_POST ||
			ph >= PH_POST_OK;
	endfunction

	function automatic logic exchanging(input phase_t ph);
		return ph != PH_IDLE && ph != PH_GAP_WAIT && ph <= PH_POST_DATAREJ;
	endfunction

	// command index and check byte per frame phase
	function automatic logic [5:0] frame_cmd(input phase_t ph);
		case (ph)
			PH_C0_FRAME:  return 6'd0;
			PH_C8_FRAME:  return 6'd8;
			PH_C55_FRAME: return 6'd55;
			PH_C41_FRAME: return 6'd41;
			PH_C58_FRAME: return 6'd58;
			PH_C16_FRAME: return 6'd16;
			PH_RD_FRAME:  return 6'd17;
			default:      return 6'd24;
		endcase
	endfunction

	function automatic logic [7:0] frame_chk(input phase_t ph);
		case (ph)
			PH_C0_FRAME:  return 8'h95;
			PH_C8_FRAME:  return 8'h87;
			PH_C55_FRAME: return 8'h65;
			PH_C41_FRAME: return 8'h77;
			PH_C58_FRAME: return 8'hFD;
			PH_C16_FRAME: return 8'h15;
			default:      return 8'hFF;
		endcase
	endfunction

	// data commands lead with two fill bytes, init commands with one
	function automatic logic [1:0] frame_gaps(input phase_t ph);
		return (ph == PH_RD_FRAME || ph == PH_WR_FRAME) ? 2'd2 : 2'd1;
	endfunction

endpackage
`default_nettype wire

### rtl/sd_card_spi_host_engine.sv
// SD card SPI-mode host sequencer. Each accepted item (start init/read/write,
// exchange done, or 1 ms tick) produces exactly one registered result item;
// a new item can be accepted every cycle while the output register is free
// or being drained. Each result says whether to exchange a byte now (tx_byte,
// select_low) and reports read bytes, completion and status. The user
// must write registers via APB only while idle; the block does not enforce it.
`default_nettype none
module sd_card_spi_host_engine #(
	parameter int BLOCK_BYTES = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave: [2:0] mode, [34:3] block_number, [42:35] rx_byte, [50:43] write_data
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,
	// master: [0] tx_valid, [8:1] tx_byte, [9] select_low, [10] data_request,
	// [11] read_valid, [19:12] read_data, [20] done_res, [23:21] status,
	// [24] high_capacity, [25] fast_clock, [26] busy_res
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int BIW = $clog2(BLOCK_BYTES) + 1;
	localparam int SH = $clog2(BLOCK_BYTES);
	localparam logic [BIW-1:0] LAST_IDX = BIW'(BLOCK_BYTES - 1);

	// configuration registers
	logic [7:0]  idle_clk_q, resp_to_q, gap_ms_q;
	logic [11:0] retry_lim_q;
	logic [23:0] token_wt_q, busy_wt_q;
	sdsh_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx = sdsh_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_clk_q <= 8'd20;
			resp_to_q <= 8'd20;
			retry_lim_q <= 12'd2000;
			gap_ms_q <= 8'd2;
			token_wt_q <= 24'd800000;
			busy_wt_q <= sdsh_pkg::MAX24;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				sdsh_pkg::RG_IDLE_CLK:  idle_clk_q <= pwdata[7:0];
				sdsh_pkg::RG_RESP_TO:   resp_to_q <= pwdata[7:0];
				sdsh_pkg::RG_RETRY_LIM: retry_lim_q <= pwdata[11:0];
				sdsh_pkg::RG_RETRY_GAP: gap_ms_q <= pwdata[7:0];
				sdsh_pkg::RG_TOKEN_WT:  token_wt_q <= pwdata[23:0];
				sdsh_pkg::RG_BUSY_WT:   busy_wt_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			sdsh_pkg::RG_IDLE_CLK:  prdata = {24'd0, idle_clk_q};
			sdsh_pkg::RG_RESP_TO:   prdata = {24'd0, resp_to_q};
			sdsh_pkg::RG_RETRY_LIM: prdata = {20'd0, retry_lim_q};
			sdsh_pkg::RG_RETRY_GAP: prdata = {24'd0, gap_ms_q};
			sdsh_pkg::RG_TOKEN_WT:  prdata = {8'd0, token_wt_q};
			sdsh_pkg::RG_BUSY_WT:   prdata = {8'd0, busy_wt_q};
			default:                prdata = 32'd0;
		endcase
	end

	// engine state
	sdsh_pkg::phase_t phase_q, ph_d;
	logic [2:0]  fidx_q, fidx_d;
	logic [31:0] arg_q, arg_d;
	logic [7:0]  r1_q, r1_d, ocr_q, ocr_d;
	logic        blk_q, blk_d, initc_q, initc_d;
	logic [11:0] retry_q, retry_d;
	logic [23:0] wait_q, wait_d;
	logic [7:0]  ms_q, ms_d;
	logic [BIW-1:0] bidx_q, bidx_d;

	logic accept;
	assign s_tready = !m_tvalid || m_tready;
	assign accept = s_tvalid && s_tready;

	sdsh_pkg::mode_t mode;
	logic [31:0] bn;
	logic [7:0]  rx, wd;
	assign mode = sdsh_pkg::mode_t'(s_tdata[2:0]);
	assign bn = s_tdata[34:3];
	assign rx = s_tdata[42:35];
	assign wd = s_tdata[50:43];

	logic issue;
	logic       r_done, r_rv;
	logic [2:0] r_st;
	logic [7:0] r_rd, tx;
	logic       dreq;
	logic [2:0] k;
	logic [1:0] gaps;

	// next-state logic for one item
	always_comb begin
		ph_d = phase_q; fidx_d = fidx_q; arg_d = arg_q; r1_d = r1_q;
		ocr_d = ocr_q; blk_d = blk_q; initc_d = initc_q; retry_d = retry_q;
		wait_d = wait_q; ms_d = ms_q; bidx_d = bidx_q;
		issue = 1'b0; r_done = 1'b0; r_st = sdsh_pkg::ST_OK;
		r_rv = 1'b0; r_rd = 8'd0;
		gaps = sdsh_pkg::frame_gaps(phase_q);
		if ((mode == sdsh_pkg::MD_INIT || mode == sdsh_pkg::MD_READ ||
				mode == sdsh_pkg::MD_WRITE) && phase_q == sdsh_pkg::PH_IDLE) begin
			issue = 1'b1;
			if (mode == sdsh_pkg::MD_INIT) begin
				if (initc_q) begin
					r_done = 1'b1;
				end else if (idle_clk_q == 8'd0) begin
					ph_d = sdsh_pkg::PH_C0_FRAME; fidx_d = 3'd0; arg_d = 32'd0;
				end else begin
					ph_d = sdsh_pkg::PH_IDLE_CLK; bidx_d = '0;
				end
			end else begin
				ph_d = (mode == sdsh_pkg::MD_READ) ? sdsh_pkg::PH_RD_FRAME
					: sdsh_pkg::PH_WR_FRAME;
				fidx_d = 3'd0;
				arg_d = blk_q ? bn : (bn << SH);
			end
		end else if (mode == sdsh_pkg::MD_XCHG && sdsh_pkg::exchanging(phase_q)) begin
			issue = 1'b1;
			if (sdsh_pkg::is_frame(phase_q)) begin
				if ({1'b0, fidx_q} >= {2'b0, gaps} + 4'd5) begin
					ph_d = sdsh_pkg::phase_t'(phase_q + 6'd1); wait_d = '0;
				end else begin
					fidx_d = fidx_q + 3'd1;
				end
			end else if (sdsh_pkg::is_poll(phase_q)) begin
				if (!rx[7] || wait_q > {16'd0, resp_to_q}) begin
					r1_d = rx;
					case (phase_q)
						sdsh_pkg::PH_C0_POLL:  ph_d = sdsh_pkg::PH_C0_POST;
						sdsh_pkg::PH_C8_POLL: begin
							ph_d = sdsh_pkg::PH_C8_R7; bidx_d = '0;
						end
						sdsh_pkg::PH_C55_POLL: ph_d = sdsh_pkg::PH_C55_POST;
						sdsh_pkg::PH_C41_POLL: ph_d = sdsh_pkg::PH_C41_POST;
						sdsh_pkg::PH_C58_POLL: begin
							ph_d = sdsh_pkg::PH_C58_OCR; bidx_d = '0;
						end
						sdsh_pkg::PH_C16_POLL: ph_d = sdsh_pkg::PH_C16_POST;
						sdsh_pkg::PH_RD_POLL: begin
							if (rx != 8'd0) ph_d = sdsh_pkg::PH_POST_CMD;
							else if (token_wt_q == 24'd0) ph_d = sdsh_pkg::PH_POST_NOTOKEN;
							else begin
								ph_d = sdsh_pkg::PH_RD_TOKEN; wait_d = token_wt_q;
							end
						end
						default: ph_d = (rx != 8'd0) ? sdsh_pkg::PH_POST_CMD
							: sdsh_pkg::PH_WR_TOKEN;
					endcase
				end
			end else begin
				case (phase_q)
					sdsh_pkg::PH_IDLE_CLK: begin
						bidx_d = bidx_q + 1'b1;
						if ({{(18-BIW){1'b0}}, bidx_d} >= {10'd0, idle_clk_q}) begin
							ph_d = sdsh_pkg::PH_C0_FRAME; fidx_d = 3'd0; arg_d = 32'd0;
						end
					end
					sdsh_pkg::PH_C0_POST: begin
						if (r1_q == 8'd0 || r1_q == 8'd1) begin
							ph_d = sdsh_pkg::PH_C8_FRAME; fidx_d = 3'd0;
							arg_d = sdsh_pkg::CMD8_ARG;
						end else begin
							ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1;
							r_st = sdsh_pkg::ST_RESET_BAD;
						end
					end
					sdsh_pkg::PH_C8_R7: begin
						if (bidx_q >= BIW'(3)) ph_d = sdsh_pkg::PH_C8_POST;
						else bidx_d = bidx_q + 1'b1;
					end
					sdsh_pkg::PH_C8_POST: begin
						retry_d = '0;
						ph_d = sdsh_pkg::PH_C55_FRAME; fidx_d = 3'd0; arg_d = 32'd0;
					end
					sdsh_pkg::PH_C55_POST: begin
						ph_d = sdsh_pkg::PH_C41_FRAME; fidx_d = 3'd0;
						arg_d = sdsh_pkg::ACMD41_ARG;
					end
					sdsh_pkg::PH_C41_POST: begin
						if (r1_q == 8'd0) begin
							ph_d = sdsh_pkg::PH_C58_FRAME; fidx_d = 3'd0; arg_d = 32'd0;
						end else if (gap_ms_q == 8'd0) begin
							if (retry_q >= retry_lim_q) begin
								ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1;
								r_st = sdsh_pkg::ST_INIT_TIMEOUT;
							end else begin
								retry_d = retry_q + 12'd1;
								ph_d = sdsh_pkg::PH_C55_FRAME; fidx_d = 3'd0; arg_d = 32'd0;
							end
						end else begin
							ph_d = sdsh_pkg::PH_GAP_WAIT; ms_d = 8'd0;
						end
					end
					sdsh_pkg::PH_C58_OCR: begin
						if (bidx_q == '0) ocr_d = rx;
						if (bidx_q >= BIW'(3)) ph_d = sdsh_pkg::PH_C58_POST;
						else bidx_d = bidx_q + 1'b1;
					end
					sdsh_pkg::PH_C58_POST: begin
						blk_d = ocr_q[6];
						initc_d = ocr_q[6];
						if (ocr_q[6]) begin
							ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1;
						end else begin
							ph_d = sdsh_pkg::PH_C16_FRAME; fidx_d = 3'd0;
							arg_d = 32'(BLOCK_BYTES);
						end
					end
					sdsh_pkg::PH_C16_POST: begin
						ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1;
						if (r1_q == 8'd0) initc_d = 1'b1;
						else r_st = sdsh_pkg::ST_BLOCKLEN;
					end
					sdsh_pkg::PH_RD_TOKEN: begin
						if (rx == sdsh_pkg::TOKEN_START) begin
							ph_d = sdsh_pkg::PH_RD_DATA; bidx_d = '0;
						end else if (wait_q <= 24'd1) begin
							wait_d = '0; ph_d = sdsh_pkg::PH_POST_NOTOKEN;
						end else begin
							wait_d = wait_q - 24'd1;
						end
					end
					sdsh_pkg::PH_RD_DATA: begin
						r_rv = 1'b1; r_rd = rx;
						if (bidx_q >= LAST_IDX) begin
							ph_d = sdsh_pkg::PH_RD_CRC; bidx_d = '0;
						end else bidx_d = bidx_q + 1'b1;
					end
					sdsh_pkg::PH_RD_CRC: begin
						if (bidx_q >= BIW'(1)) ph_d = sdsh_pkg::PH_POST_OK;
						else bidx_d = bidx_q + 1'b1;
					end
					sdsh_pkg::PH_WR_TOKEN: begin
						ph_d = sdsh_pkg::PH_WR_DATA; bidx_d = '0;
					end
					sdsh_pkg::PH_WR_DATA: begin
						if (bidx_q >= LAST_IDX) begin
							ph_d = sdsh_pkg::PH_WR_CRC; bidx_d = '0;
						end else bidx_d = bidx_q + 1'b1;
					end
					sdsh_pkg::PH_WR_CRC: begin
						if (bidx_q >= BIW'(1)) ph_d = sdsh_pkg::PH_WR_RESP;
						else bidx_d = bidx_q + 1'b1;
					end
					sdsh_pkg::PH_WR_RESP: begin
						if (rx[4:0] != 5'h05) ph_d = sdsh_pkg::PH_POST_DATAREJ;
						else if (busy_wt_q == 24'd0) ph_d = sdsh_pkg::PH_POST_OK;
						else begin
							ph_d = sdsh_pkg::PH_WR_BUSY; wait_d = busy_wt_q;
						end
					end
					sdsh_pkg::PH_WR_BUSY: begin
						if (rx == sdsh_pkg::FILL_BYTE || wait_q <= 24'd1) begin
							wait_d = '0; ph_d = sdsh_pkg::PH_POST_OK;
						end else wait_d = wait_q - 24'd1;
					end
					sdsh_pkg::PH_POST_OK: begin
						ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1;
					end
					sdsh_pkg::PH_POST_CMD: begin
						ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1; r_st = sdsh_pkg::ST_CMD_REJ;
					end
					sdsh_pkg::PH_POST_NOTOKEN: begin
						ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1; r_st = sdsh_pkg::ST_NO_TOKEN;
					end
					sdsh_pkg::PH_POST_DATAREJ: begin
						ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1; r_st = sdsh_pkg::ST_DATA_REJ;
					end
					default: ;
				endcase
			end
		end else if (mode == sdsh_pkg::MD_TICK) begin
			if (sdsh_pkg::is_poll(phase_q)) begin
				if (wait_q < sdsh_pkg::MAX24) wait_d = wait_q + 24'd1;
			end else if (phase_q == sdsh_pkg::PH_GAP_WAIT) begin
				ms_d = ms_q + 8'd1;
				if (ms_d >= gap_ms_q) begin
					issue = 1'b1;
					if (retry_q >= retry_lim_q) begin
						ph_d = sdsh_pkg::PH_IDLE; r_done = 1'b1;
						r_st = sdsh_pkg::ST_INIT_TIMEOUT;
					end else begin
						retry_d = retry_q + 12'd1;
						ph_d = sdsh_pkg::PH_C55_FRAME; fidx_d = 3'd0; arg_d = 32'd0;
					end
				end
			end
		end
	end

	// outgoing byte for the new phase
	logic issue_o;
	logic [1:0] gaps_n;
	always_comb begin
		issue_o = issue && sdsh_pkg::exchanging(ph_d);
		tx = 8'd0;
		dreq = 1'b0;
		gaps_n = sdsh_pkg::frame_gaps(ph_d);
		k = fidx_d - {1'b0, gaps_n};
		if (issue_o) begin
			if (sdsh_pkg::is_frame(ph_d)) begin
				if (fidx_d < {1'b0, gaps_n}) tx = sdsh_pkg::FILL_BYTE;
				else begin
					case (k)
						3'd0: tx = sdsh_pkg::CMD_MARK | {2'b0, sdsh_pkg::frame_cmd(ph_d)};
						3'd1: tx = arg_d[31:24];
						3'd2: tx = arg_d[23:16];
						3'd3: tx = arg_d[15:8];
						3'd4: tx = arg_d[7:0];
						3'd5: tx = sdsh_pkg::frame_chk(ph_d);
						default: tx = sdsh_pkg::FILL_BYTE;
					endcase
				end
			end else if (ph_d == sdsh_pkg::PH_WR_TOKEN) tx = sdsh_pkg::TOKEN_START;
			else if (ph_d == sdsh_pkg::PH_WR_DATA) tx = wd;
			else tx = sdsh_pkg::FILL_BYTE;
			dreq = ph_d == sdsh_pkg::PH_WR_TOKEN ||
				(ph_d == sdsh_pkg::PH_WR_DATA && bidx_d < LAST_IDX);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdsh_pkg::PH_IDLE;
			fidx_q <= '0; arg_q <= '0; r1_q <= 8'hFF; ocr_q <= '0;
			blk_q <= 1'b0; initc_q <= 1'b0; retry_q <= '0; wait_q <= '0;
			ms_q <= '0; bidx_q <= '0;
		end else if (accept) begin
			phase_q <= ph_d;
			fidx_q <= fidx_d; arg_q <= arg_d; r1_q <= r1_d; ocr_q <= ocr_d;
			blk_q <= blk_d; initc_q <= initc_d; retry_q <= retry_d; wait_q <= wait_d;
			ms_q <= ms_d; bidx_q <= bidx_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (accept) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata <= {5'd0, ph_d != sdsh_pkg::PH_IDLE, initc_d, blk_d, r_st, r_done,
				r_rd, r_rv, dreq, !sdsh_pkg::cs_high(ph_d), tx, issue_o};
		end
	end

	logic [4:0] unused_hi;
	assign unused_hi = s_tdata[55:51];
	logic unused_ok;
	assign unused_ok = ^{unused_hi, pwdata[31:24]};

`ifndef NO_ASSERTIONS
	// a completed operation always leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> !m_tdata[26])
		else $error("done reported while busy");
	// data request only comes with an exchange
	a_dreq_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tdata[0])
		else $error("data request without exchange");
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire
